// ----- sv/rans_alias_symbol_encoder_unit_defines.svh -----
// ----------------------------------------------------------------------------
// rans_alias_symbol_encoder_unit_defines
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef RANS_ALIAS_SYMBOL_ENCODER_UNIT_DEFINES_SVH
`define RANS_ALIAS_SYMBOL_ENCODER_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define RAS_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication outside reset
`define RAS_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ----- sv/ras_pkg.sv -----
// ----------------------------------------------------------------------------
// ras_pkg
// shared types and constants of the rans alias symbol encoder
// ----------------------------------------------------------------------------
package ras_pkg;

  localparam int Alphabet   = 256;
  localparam int TableSlots = 4096;
  localparam int SymW       = 8;
  localparam int SlotW      = 12;
  localparam int FreqW      = 13;
  localparam int StateW     = 32;
  localparam int OutBits    = 16;
  localparam int PrecBits   = 12;
  localparam int RenormSh   = 20;
  localparam logic [StateW-1:0] InitStateRst = 32'd1245184;

  typedef enum logic [2:0] {
    OP_LOAD_COUNT = 3'd0,
    OP_LOAD_ALIAS = 3'd1,
    OP_BUILD      = 3'd2,
    OP_ENCODE     = 3'd3,
    OP_RESET_ST   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SUM  = 2'd1,
    ST_ZERO_SYM = 2'd2
  } status_t;

  // divider start / done exchange
  typedef struct packed {
    logic              start;
    logic [StateW-1:0] dividend;
    logic [FreqW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [StateW-1:0] quot;
    logic [FreqW-1:0]  rem;
  } div_rsp_t;

endpackage

// ----- sv/rans_alias_symbol_encoder_unit.sv -----
// sequencing: load and reset-state beats are taken in S_IDLE with no result beat; encode
// runs S_ENRD, S_ENDIV (serial divide), S_ENMAP and S_ENFIN to S_OUT, a zero-frequency
// encode S_ENRD only; build runs S_PFX over all 256 counts, then S_SLOTRD, S_SLOTCH and
// S_SLOTWR per slot for 4096 slots; throughput: one item at a time, in_stall high until
// the result beat is taken, encode rate set by the serial divider
// reset: synchronous; S_CLEAR clears counts, offsets and alias tables of 256 symbols first
// ----------------------------------------------------------------------------
// rans_alias_symbol_encoder_unit
// rANS encoder with alias-mapped 4096-slot table and serial divider
// ----------------------------------------------------------------------------
module rans_alias_symbol_encoder_unit import ras_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [7:0]  index,
  input  logic [12:0] count,
  input  logic [4:0]  cutoff,
  input  logic [7:0]  right_symbol,
  input  logic [11:0] right_base,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] new_state,
  output logic        renorm_valid,
  output logic [15:0] renorm_bits,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_PFX    = 11'b00000000100,
    S_SLOTRD = 11'b00000001000,
    S_SLOTCH = 11'b00000010000,
    S_SLOTWR = 11'b00000100000,
    S_ENRD   = 11'b00001000000,
    S_ENDIV  = 11'b00010000000,
    S_ENMAP  = 11'b00100000000,
    S_ENFIN  = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_t;

  state_t st;

  // memories
  logic [FreqW-1:0] freq_mem  [Alphabet];
  logic [FreqW-1:0] start_mem [Alphabet];
  logic [4:0]       cut_mem   [Alphabet];
  logic [SymW-1:0]  rsym_mem  [Alphabet];
  logic [SlotW-1:0] roff_mem  [Alphabet];
  logic [SlotW-1:0] slot_mem  [TableSlots];

  logic [StateW-1:0] init_state, coder_state, work;
  logic [8:0]        cnt;
  logic [SlotW-1:0]  slot;
  logic [FreqW-1:0]  run_start;
  logic [20:0]       sum;
  logic [FreqW-1:0]  freq_q, start_q;
  logic [4:0]        cut_q;
  logic [SymW-1:0]   rsym_q;
  logic [SlotW-1:0]  roff_q;
  logic [FreqW-1:0]  off;
  logic [SlotW-1:0]  map_q;
  logic [SlotW-1:0]  wr_addr;
  logic              rv;
  logic [15:0]       rb;
  logic [1:0]        stat;
  logic [StateW-1:0] quot;
  logic [SymW-1:0]   enc_sym;
  logic              renorm;

  div_req_t dreq;
  div_rsp_t drsp;

  ras_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic in_acc, out_acc;
  assign in_stall  = (st != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (st == S_OUT);
  assign out_acc   = out_valid && !out_stall;
  assign cfg_ready = 1'b1;

  // renormalisation ahead of the divide
  assign renorm = ({1'b0, coder_state[StateW-1:RenormSh]} >= freq_q);
  assign work   = renorm ? {16'd0, coder_state[StateW-1:OutBits]} : coder_state;

  // alias choice for the current slot
  logic [SymW-1:0] sel_sym;
  logic [FreqW-1:0] sel_off;
  always_comb begin
    sel_sym = slot[SlotW-1:4];
    sel_off = {9'd0, slot[3:0]};
    if ({1'b0, slot[3:0]} >= cut_q) begin
      sel_sym = rsym_q;
      sel_off = {9'd0, slot[3:0]} + {1'b0, roff_q};
    end
  end

  // shared read address for the per-symbol tables
  logic [SymW-1:0] rd_addr;
  always_comb begin
    rd_addr = cnt[SymW-1:0];
    if (st == S_IDLE) rd_addr = index;
    else if (st == S_SLOTRD) rd_addr = slot[SlotW-1:4];
    else if (st == S_SLOTCH) rd_addr = sel_sym;
    else if (st == S_ENRD || st == S_ENDIV || st == S_ENMAP) rd_addr = enc_sym;
  end

  // table memories, registered reads
  always_ff @(posedge clk) begin
    freq_q  <= freq_mem[rd_addr];
    start_q <= start_mem[rd_addr];
    cut_q   <= cut_mem[rd_addr];
    rsym_q  <= rsym_mem[rd_addr];
    roff_q  <= roff_mem[rd_addr];
    map_q   <= slot_mem[wr_addr];
    if (st == S_CLEAR) begin
      freq_mem[cnt[SymW-1:0]]  <= '0;
      start_mem[cnt[SymW-1:0]] <= '0;
      cut_mem[cnt[SymW-1:0]]   <= '0;
      rsym_mem[cnt[SymW-1:0]]  <= '0;
      roff_mem[cnt[SymW-1:0]]  <= '0;
    end else if (in_acc && opcode == OP_LOAD_COUNT) begin
      freq_mem[index] <= count;
    end else if (in_acc && opcode == OP_LOAD_ALIAS) begin
      cut_mem[index]  <= cutoff;
      rsym_mem[index] <= right_symbol;
      roff_mem[index] <= right_base;
    end else if (st == S_PFX && cnt != 9'd0) begin
      start_mem[cnt[SymW-1:0] - 1'b1] <= run_start;
    end
    if (st == S_SLOTWR && off < freq_q) slot_mem[wr_addr] <= slot;
  end

  // slot map address: build write or encode lookup
  always_comb begin
    if (st == S_SLOTWR) wr_addr = SlotW'(start_q + off);
    else wr_addr = SlotW'(start_q + drsp.rem);
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_CLEAR;
      cnt         <= '0;
      init_state  <= InitStateRst;
      coder_state <= InitStateRst;
      dreq.start  <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      if (cfg_valid && cfg_ready) init_state <= cfg_data;
      unique case (st)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == 9'(Alphabet - 1)) st <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            unique case (opcode)
              OP_BUILD: begin
                st <= S_PFX; cnt <= '0; run_start <= '0; sum <= '0;
              end
              OP_ENCODE: begin
                enc_sym <= index; st <= S_ENRD;
              end
              OP_RESET_ST: coder_state <= init_state;
              default: ;
            endcase
          end
        end
        S_PFX: begin
          // freq_q holds entry cnt-1 here whenever cnt is non-zero
          if (cnt != 9'd0) begin
            run_start <= run_start + freq_q;
            sum <= sum + {8'd0, freq_q};
          end
          if (cnt == 9'(Alphabet)) begin
            st <= S_SLOTRD; slot <= '0;
          end
          cnt <= cnt + 1'b1;
        end
        S_SLOTRD: st <= S_SLOTCH;
        S_SLOTCH: begin
          off <= sel_off; st <= S_SLOTWR;
        end
        S_SLOTWR: begin
          slot <= slot + 1'b1;
          if (slot == SlotW'(TableSlots - 1)) begin
            stat <= (sum != 21'd4096) ? ST_BAD_SUM : ST_OK;
            new_state <= coder_state; rv <= 1'b0; rb <= '0;
            st <= S_OUT;
          end else st <= S_SLOTRD;
        end
        S_ENRD: begin
          rv <= 1'b0; rb <= '0; stat <= ST_OK;
          if (freq_q == '0) begin
            stat <= ST_ZERO_SYM; new_state <= coder_state; st <= S_OUT;
          end else begin
            if (renorm) begin
              rv <= 1'b1; rb <= coder_state[OutBits-1:0];
            end
            dreq.start    <= 1'b1;
            dreq.dividend <= work;
            dreq.divisor  <= freq_q;
            st <= S_ENDIV;
          end
        end
        S_ENDIV: if (drsp.done) st <= S_ENMAP;
        S_ENMAP: begin
          quot <= drsp.quot; st <= S_ENFIN;
        end
        S_ENFIN: begin
          coder_state <= {quot[StateW-1-PrecBits:0], {PrecBits{1'b0}}} + {20'd0, map_q};
          new_state   <= {quot[StateW-1-PrecBits:0], {PrecBits{1'b0}}} + {20'd0, map_q};
          st <= S_OUT;
        end
        S_OUT: if (out_acc) st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end

  assign renorm_valid = rv;
  assign renorm_bits  = rb;
  assign status       = stat;

endmodule

// ----- sv/ras_divider.sv -----
// ----------------------------------------------------------------------------
// ras_divider
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ras_divider import ras_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CntW = $clog2(StateW + 1);

  logic [StateW-1:0] quot;
  logic [FreqW:0]    rem;
  logic [FreqW-1:0]  dvs;
  logic [CntW-1:0]   cnt;
  logic              busy;
  logic              done;

  logic [FreqW+1:0] trial;
  assign trial = {rem, quot[StateW-1]} - {2'b00, dvs};

  // shift one dividend bit into the partial remainder per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CntW'(StateW);
        quot <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        if (!trial[FreqW+1]) begin
          rem <= trial[FreqW:0];
          quot <= {quot[StateW-2:0], 1'b1};
        end else begin
          rem <= {rem[FreqW-1:0], quot[StateW-1]};
          quot <= {quot[StateW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem[FreqW-1:0];

endmodule

// ----- sv/ras_checker.sv -----
// ----------------------------------------------------------------------------
// ras_checker
// port-level checks of the encoder handshakes and result fields
// ----------------------------------------------------------------------------
`include "rans_alias_symbol_encoder_unit_defines.svh"

module ras_checker import ras_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] new_state,
  input logic        renorm_valid,
  input logic [15:0] renorm_bits,
  input logic [1:0]  status
);

  // result held while stalled
  `RAS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(new_state))
  // no input taken while a result waits
  `RAS_ASSERT_IMP(a_busy_out, clk, rst, out_valid && in_valid, in_stall)
  // renorm bits zero without renorm
  `RAS_ASSERT_IMP(a_rb_zero, clk, rst, out_valid && !renorm_valid, renorm_bits == 16'd0)
  // status code range
  `RAS_ASSERT_IMP(a_status, clk, rst, out_valid, status != 2'd3)

endmodule

bind rans_alias_symbol_encoder_unit ras_checker u_ras_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .new_state(new_state),
  .renorm_valid(renorm_valid), .renorm_bits(renorm_bits), .status(status)
);
